/* hdl/lir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_pkg - shared types and constants of the linear interpolating resampler
// Default parameter values, status codes and the control word that travels
// with each queued command.
// ----------------------------------------------------------------------------
package lir_pkg;

   // defaults of the top level parameters
   localparam int MAX_RUN_DEF    = 64;
   localparam int TIME_BITS_DEF  = 32;
   localparam int VALUE_BITS_DEF = 32;

   // width of the grid step register
   localparam int STEP_BITS = 32;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // width of one operand slice of the back end multiplier
   localparam int MUL_CHUNK = 16;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DROP = 2'd1,
      ST_OVER = 2'd2
   } status_type;

   // control part of a queued command
   typedef struct packed {
      status_type status;
      logic       last;
   } ctrl_type;

   localparam int CTRL_BITS = $bits(ctrl_type);

endpackage
`default_nettype wire

/* hdl/lir_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_queue - command queue between front and back
// Small register FIFO with valid/ready on both sides; each side stalls on
// its own.
// ----------------------------------------------------------------------------
module lir_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_xfer, pop_xfer;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_xfer  = push_valid && push_ready;
   assign pop_xfer   = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_xfer) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

/* hdl/lir_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_front - point intake and segment classification
// Holds the grid step and the series state, classifies each point and
// queues one command per result: a status result or a grid sample.
// ----------------------------------------------------------------------------
module lir_front #(
   parameter int MAX_RUN    = lir_pkg::MAX_RUN_DEF,
   parameter int TIME_BITS  = lir_pkg::TIME_BITS_DEF,
   parameter int VALUE_BITS = lir_pkg::VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [lir_pkg::STEP_BITS-1:0] csr_grid_step,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_series_start,
   input  wire logic [TIME_BITS-1:0]         req_point_time,
   input  wire logic signed [VALUE_BITS-1:0] req_point_value,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output logic [lir_pkg::CTRL_BITS+3*TIME_BITS+2*VALUE_BITS-1:0] push_data
);

   localparam int SB    = lir_pkg::STEP_BITS;
   localparam int RUN_W = $clog2(MAX_RUN + 1);
   localparam int LIM_W = SB + RUN_W;
   localparam int CMP_W = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;
   localparam int SUM_W = ((TIME_BITS > SB) ? TIME_BITS : SB) + 1;

   typedef enum logic [2:0] {
      FS_IDLE     = 3'b001,
      FS_CLASSIFY = 3'b010,
      FS_RUN      = 3'b100
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [SB-1:0]         grid_step_ff;
   logic [LIM_W-1:0]      run_limit_ff, run_limit_in;
   logic                  have_prev_ff, have_prev_in;
   logic [TIME_BITS-1:0]  prev_time_ff, prev_time_in;
   logic [VALUE_BITS-1:0] prev_value_ff, prev_value_in;
   logic [TIME_BITS:0]    next_grid_ff, next_grid_in;
   logic                  item_start_ff;
   logic [TIME_BITS-1:0]  item_time_ff;
   logic [VALUE_BITS-1:0] item_value_ff;

   logic [SB-1:0]         step_eff;
   logic                  grid_le, over, run_last, grid_clamp;
   logic [TIME_BITS-1:0]  gap;
   logic [SUM_W-1:0]      grid_sum;
   logic [TIME_BITS:0]    grid_next;
   lir_pkg::ctrl_type     push_ctrl;
   logic [TIME_BITS-1:0]  push_time, push_t0, push_t1;
   logic [VALUE_BITS-1:0] push_v0, push_v1;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == FS_IDLE);

   // a zero step acts as one; run limit kept registered
   assign step_eff     = (grid_step_ff == '0) ? SB'(1) : grid_step_ff;
   assign run_limit_in = LIM_W'(step_eff) * LIM_W'(MAX_RUN);

   // segment classification
   assign grid_le = (next_grid_ff <= {1'b0, item_time_ff});
   assign gap     = item_time_ff - next_grid_ff[TIME_BITS-1:0];
   assign over    = (CMP_W'(gap) >= CMP_W'(run_limit_ff));

   // next grid time, pinned just above the time range once past it
   assign grid_sum   = SUM_W'(next_grid_ff) + SUM_W'(step_eff);
   assign grid_clamp = ((grid_sum >> TIME_BITS) != '0);
   assign grid_next  = grid_clamp ? {1'b1, {TIME_BITS{1'b0}}}
                                  : {1'b0, grid_sum[TIME_BITS-1:0]};
   assign run_last   = (grid_next > {1'b0, item_time_ff});

   assign push_data = {push_ctrl, push_time, push_t0, push_t1, push_v0, push_v1};

   // sequencing of one point
   always_comb begin
      state_in         = state_ff;
      have_prev_in     = have_prev_ff;
      prev_time_in     = prev_time_ff;
      prev_value_in    = prev_value_ff;
      next_grid_in     = next_grid_ff;
      push_valid       = 1'b0;
      push_ctrl.status = lir_pkg::ST_OK;
      push_ctrl.last   = run_last;
      push_time        = next_grid_ff[TIME_BITS-1:0];
      push_t0          = prev_time_ff;
      push_t1          = item_time_ff;
      push_v0          = prev_value_ff;
      push_v1          = item_value_ff;
      case (state_ff)
         FS_IDLE: begin
            if (req_valid) begin
               state_in = FS_CLASSIFY;
            end
         end
         FS_CLASSIFY: begin
            if (item_start_ff || !have_prev_ff) begin
               // open a series at this point
               have_prev_in  = 1'b1;
               prev_time_in  = item_time_ff;
               prev_value_in = item_value_ff;
               next_grid_in  = {1'b0, item_time_ff};
               state_in      = FS_IDLE;
            end else if (item_time_ff < prev_time_ff) begin
               // out of order: status result, state kept
               push_valid       = 1'b1;
               push_ctrl.status = lir_pkg::ST_DROP;
               push_ctrl.last   = 1'b1;
               push_time        = '0;
               push_t0          = '0;
               push_t1          = '0;
               push_v0          = '0;
               push_v1          = '0;
               if (push_ready) begin
                  state_in = FS_IDLE;
               end
            end else if (!grid_le) begin
               // no grid time in this segment
               prev_time_in  = item_time_ff;
               prev_value_in = item_value_ff;
               state_in      = FS_IDLE;
            end else if (over) begin
               // run too long: status result and restart
               push_valid       = 1'b1;
               push_ctrl.status = lir_pkg::ST_OVER;
               push_ctrl.last   = 1'b1;
               push_time        = '0;
               push_t0          = '0;
               push_t1          = '0;
               push_v0          = '0;
               push_v1          = '0;
               if (push_ready) begin
                  have_prev_in  = 1'b1;
                  prev_time_in  = item_time_ff;
                  prev_value_in = item_value_ff;
                  next_grid_in  = {1'b0, item_time_ff};
                  state_in      = FS_IDLE;
               end
            end else begin
               state_in = FS_RUN;
            end
         end
         FS_RUN: begin
            // one sample command per grid time
            push_valid = 1'b1;
            if (push_ready) begin
               next_grid_in = grid_next;
               if (run_last) begin
                  prev_time_in  = item_time_ff;
                  prev_value_in = item_value_ff;
                  state_in      = FS_IDLE;
               end
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   // control and series state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FS_IDLE;
         grid_step_ff  <= SB'(1);
         have_prev_ff  <= 1'b0;
         prev_time_ff  <= '0;
         prev_value_ff <= '0;
         next_grid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         prev_time_ff  <= prev_time_in;
         prev_value_ff <= prev_value_in;
         next_grid_ff  <= next_grid_in;
         if (csr_valid && csr_ready) begin
            grid_step_ff <= csr_grid_step;
         end
      end
   end

   // point capture and run limit
   always_ff @(posedge clock) begin
      run_limit_ff <= run_limit_in;
      if (req_valid && req_ready) begin
         item_start_ff <= req_series_start;
         item_time_ff  <= req_point_time;
         item_value_ff <= req_point_value;
      end
   end

`ifndef ASSERT_OFF
   a_run_in_segment : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_RUN) |-> (next_grid_ff <= {1'b0, item_time_ff}))
      else $error("grid time beyond segment end during run");
`endif

endmodule
`default_nettype wire

/* hdl/lir_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lir_back - interpolation of one queued sample
// Forms |v1-v0| * (g-t0) in slices, divides by (t1-t0) one quotient bit a
// cycle and presents the result through an output register.
// ----------------------------------------------------------------------------
module lir_back #(
   parameter int TIME_BITS  = lir_pkg::TIME_BITS_DEF,
   parameter int VALUE_BITS = lir_pkg::VALUE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire logic [lir_pkg::CTRL_BITS+3*TIME_BITS+2*VALUE_BITS-1:0] pop_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [TIME_BITS-1:0]           rsp_out_time,
   output logic signed [VALUE_BITS-1:0]   rsp_out_value,
   output logic                           rsp_last_of_run,
   output logic [1:0]                     rsp_status
);

   localparam int CH    = lir_pkg::MUL_CHUNK;
   localparam int NCH   = (TIME_BITS + CH - 1) / CH;
   localparam int XP    = NCH * CH;
   localparam int PW    = VALUE_BITS + XP;
   localparam int PPW   = VALUE_BITS + CH;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   typedef enum logic [3:0] {
      BS_IDLE = 4'b0001,
      BS_MUL  = 4'b0010,
      BS_DIV  = 4'b0100,
      BS_DONE = 4'b1000
   } back_state_type;

   back_state_type        state_ff, state_in;
   lir_pkg::ctrl_type     ctrl_ff, ctrl_in;
   logic [TIME_BITS-1:0]  g_ff, g_in;
   logic [VALUE_BITS-1:0] v0_ff, v0_in;
   logic [TIME_BITS-1:0]  den_ff, den_in;
   logic [XP-1:0]         x_ff, x_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  zero_len_ff, zero_len_in;
   logic [PPW-1:0]        pp_ff, pp_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0]  rsp_time_ff, rsp_time_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   lir_pkg::ctrl_type     e_ctrl;
   logic [TIME_BITS-1:0]  e_g, e_t0, e_t1;
   logic [VALUE_BITS-1:0] e_v0, e_v1;
   logic [VALUE_BITS:0]   diff, diff_abs;
   logic [TIME_BITS:0]    trial;
   logic                  trial_ge;
   logic [VALUE_BITS-1:0] interp;
   logic                  out_free;

   assign {e_ctrl, e_g, e_t0, e_t1, e_v0, e_v1} = pop_data;

   assign pop_ready = (state_ff == BS_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // signed difference of the segment end values
   assign diff     = {e_v1[VALUE_BITS-1], e_v1} - {e_v0[VALUE_BITS-1], e_v0};
   assign diff_abs = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;

   // restoring division step
   assign trial    = {rem_ff, q_ff[VALUE_BITS-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});

   // interpolated value, always between the end values
   assign interp = neg_ff ? (v0_ff - q_ff) : (v0_ff + q_ff);

   always_comb begin
      state_in      = state_ff;
      ctrl_in       = ctrl_ff;
      g_in          = g_ff;
      v0_in         = v0_ff;
      den_in        = den_ff;
      x_in          = x_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      zero_len_in   = zero_len_ff;
      pp_in         = pp_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_time_in   = rsp_time_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         BS_IDLE: begin
            // take the next command
            if (pop_valid) begin
               ctrl_in     = e_ctrl;
               g_in        = e_g;
               v0_in       = e_v0;
               den_in      = e_t1 - e_t0;
               x_in        = XP'(e_g - e_t0);
               mag_in      = diff_abs[VALUE_BITS-1:0];
               neg_in      = diff[VALUE_BITS];
               zero_len_in = (e_t1 == e_t0);
               acc_in      = '0;
               cnt_in      = '0;
               if ((e_ctrl.status != lir_pkg::ST_OK) || (e_t1 == e_t0)) begin
                  state_in = BS_DONE;
               end else begin
                  state_in = BS_MUL;
               end
            end
         end
         BS_MUL: begin
            // slice products, most significant slice first
            if (cnt_ff < CNT_W'(NCH)) begin
               pp_in = PPW'(mag_ff) * PPW'(x_ff[XP-1 -: CH]);
               x_in  = x_ff << CH;
            end
            if (cnt_ff != '0) begin
               acc_in = (acc_ff << CH) + PW'(pp_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NCH)) begin
               rem_in   = acc_in[VALUE_BITS +: TIME_BITS];
               q_in     = acc_in[VALUE_BITS-1:0];
               cnt_in   = '0;
               state_in = BS_DIV;
            end
         end
         BS_DIV: begin
            // one quotient bit a cycle
            rem_in = trial_ge ? TIME_BITS'(trial - {1'b0, den_ff})
                              : TIME_BITS'(trial);
            q_in   = {q_ff[VALUE_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               state_in = BS_DONE;
            end
         end
         BS_DONE: begin
            // hand over to the output register
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = ctrl_ff.last;
               rsp_status_in = ctrl_ff.status;
               if (ctrl_ff.status != lir_pkg::ST_OK) begin
                  rsp_time_in  = '0;
                  rsp_value_in = '0;
               end else begin
                  rsp_time_in  = g_ff;
                  rsp_value_in = zero_len_ff ? v0_ff : interp;
               end
               state_in = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ctrl_ff       <= ctrl_in;
      g_ff          <= g_in;
      v0_ff         <= v0_in;
      den_ff        <= den_in;
      x_ff          <= x_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      zero_len_ff   <= zero_len_in;
      pp_ff         <= pp_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_time    = rsp_time_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef ASSERT_OFF
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_DIV) |-> (den_ff != '0))
      else $error("division entered with zero segment length");
   a_status_form : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != lir_pkg::ST_OK))
         |-> (rsp_last_ff && (rsp_time_ff == '0) && (rsp_value_ff == '0)))
      else $error("status result not a lone zero result");
`endif

endmodule
`default_nettype wire

/* hdl/linear_interp_resampler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_interp_resampler_top - streaming linear resampler onto a time grid
// Points (series_start, time, value) enter on the req_ channel; each point
// that closes a segment yields one rsp_ transfer per grid time in it, the
// final one marked last_of_run, or a single status transfer.
// The csr_ channel writes the grid step (always ready); write it only while
// the block is idle.
// Each command passes from the front through the queue to the back end. For
// a grid sample the back forms the product in NCH = ceil(TIME_BITS/16)
// slices and then runs the restoring divider, which yields one quotient bit
// a cycle; status results and zero-length segments skip both steps. The back
// takes the next command only after it has handed its result to the output
// register. The front queues sample commands ahead of the back through a
// four-entry queue and takes the next point once its commands are queued.
// req_ready is high while the front waits for a point. When the receiver
// stalls the result holds in the output register, the back finishes its
// current sample and the queue fills, after which the front waits.
// Reset (synchronous) closes any open series, empties the queue, drops any
// pending result and sets the grid step to one.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top #(
   parameter int MAX_RUN    = lir_pkg::MAX_RUN_DEF,
   parameter int TIME_BITS  = lir_pkg::TIME_BITS_DEF,
   parameter int VALUE_BITS = lir_pkg::VALUE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lir_pkg::STEP_BITS-1:0] csr_grid_step,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_series_start,
   input  wire logic [TIME_BITS-1:0]          req_point_time,
   input  wire logic signed [VALUE_BITS-1:0]  req_point_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [TIME_BITS-1:0]               rsp_out_time,
   output logic signed [VALUE_BITS-1:0]       rsp_out_value,
   output logic                               rsp_last_of_run,
   output logic [1:0]                         rsp_status
);

   localparam int ENTRY_W = lir_pkg::CTRL_BITS + 3 * TIME_BITS + 2 * VALUE_BITS;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // intake and classification
   lir_front #(
      .MAX_RUN    (MAX_RUN),
      .TIME_BITS  (TIME_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_step    (csr_grid_step),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_series_start (req_series_start),
      .req_point_time   (req_point_time),
      .req_point_value  (req_point_value),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // command queue
   lir_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (lir_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // interpolation and output
   lir_back #(
      .TIME_BITS  (TIME_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_time    (rsp_out_time),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire

/* test/linear_interp_resampler_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_top_test - self-checking bench of the grid resampler
// Streams series points into the block and predicts every grid sample and
// status transfer in the bench itself, then checks each result transfer
// field by field in order. A directed pass hits the corner cases. Random
// phases follow, with several grid steps and different idle patterns on both
// channels. A back-pressure pass fills the block while the receiver holds off.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top_test;

   localparam int TW = lir_pkg::TIME_BITS_DEF;
   localparam int VW = lir_pkg::VALUE_BITS_DEF;
   localparam int SW = lir_pkg::STEP_BITS;
   localparam int RUN_LIMIT = lir_pkg::MAX_RUN_DEF;
   localparam longint unsigned TIME_MAX = (64'd1 << TW) - 1;
   // quiet time after the last sample, covers a point still being classified
   localparam int SETTLE_CYCLES = 120;
   // about 370 points at 64 samples each with stalls, several times over
   localparam int CYCLE_LIMIT = 5_000_000;

   typedef struct packed {
      logic [TW-1:0]       grid_time;
      logic [VW-1:0]       sample_value;
      logic                is_last;
      lir_pkg::status_type status;
   } sample_type;

   // clock, reset and block inputs, all known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SW-1:0]        csr_grid_step = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_series_start = 1'b0;
   logic [TW-1:0]        req_point_time = '0;
   logic [VW-1:0]        req_point_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TW-1:0]        rsp_out_time;
   logic [VW-1:0]        rsp_out_value;
   logic                 rsp_last_of_run;
   logic [1:0]           rsp_status;

   // resampler state as the bench sees it
   logic [SW-1:0]        grid_step_reg = 1;
   logic                 series_open = 1'b0;
   logic [TW-1:0]        last_time = '0;
   logic [VW-1:0]        last_value = '0;
   logic [TW:0]          next_grid = '0;
   sample_type           expected_samples[$];

   // stimulus knobs and bookkeeping
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   hold_off_cycles = 0;
   int                   fail_count = 0;
   int                   sample_count = 0;
   int                   cycle_count = 0;
   longint unsigned      gen_time = 0;
   bit                   gen_open = 1'b0;

   linear_interp_resampler_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_step    (csr_grid_step),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_series_start (req_series_start),
      .req_point_time   (req_point_time),
      .req_point_value  (req_point_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_time     (rsp_out_time),
      .rsp_out_value    (rsp_out_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_status       (rsp_status)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linear_interp_resampler_top_test: FAIL");
         $finish;
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch: %s", msg);
   endtask

   // result checker, oldest expectation first
   always @(posedge clock) begin : check_results
      sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer t=%h v=%h last=%b st=%0d",
               rsp_out_time, rsp_out_value, rsp_last_of_run, rsp_status));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_out_time !== want.grid_time || rsp_out_value !== want.sample_value ||
                rsp_last_of_run !== want.is_last || rsp_status !== want.status) begin
               report_mismatch($sformatf(
                  "sample %0d got t=%h v=%h last=%b st=%0d, want t=%h v=%h last=%b st=%0d",
                  sample_count, rsp_out_time, rsp_out_value, rsp_last_of_run, rsp_status,
                  want.grid_time, want.sample_value, want.is_last, want.status));
            end
         end
         sample_count++;
      end
   end

   // appends one expected result at the tail
   task automatic expect_sample(input logic [TW-1:0] t, input logic [VW-1:0] v,
                                input logic last, input lir_pkg::status_type st);
      sample_type s;
      s.grid_time = t;
      s.sample_value = v;
      s.is_last = last;
      s.status = st;
      expected_samples.insert(expected_samples.size(), s);
   endtask

   task automatic open_series(input logic [TW-1:0] t, input logic [VW-1:0] v);
      series_open = 1'b1;
      last_time = t;
      last_value = v;
      next_grid = {1'b0, t};
   endtask

   // works out the samples one accepted point causes and updates the state
   task automatic predict_point(input logic start, input logic [TW-1:0] t,
                                input logic [VW-1:0] v);
      logic [TW:0]   step_eff;
      logic [TW:0]   grid;
      logic [TW:0]   run_len;
      logic [VW:0]   diff;
      logic [VW:0]   mag;
      logic [95:0]   product;
      logic [95:0]   quotient;
      logic [VW+1:0] interp;
      int            k;
      // a zero step behaves as one tick
      step_eff = (grid_step_reg == '0) ? 1 : {1'b0, grid_step_reg};
      if (start || !series_open) begin
         open_series(t, v);
      end else if (t < last_time) begin
         // out-of-order point is dropped, state kept
         expect_sample('0, '0, 1'b1, lir_pkg::ST_DROP);
      end else begin
         grid = next_grid;
         run_len = (grid <= {1'b0, t}) ? ({1'b0, t} - grid) / step_eff + 1 : '0;
         if (run_len > RUN_LIMIT) begin
            // too many samples: flag and restart the series here
            expect_sample('0, '0, 1'b1, lir_pkg::ST_OVER);
            open_series(t, v);
         end else begin
            diff = {v[VW-1], v} - {last_value[VW-1], last_value};
            mag = diff[VW] ? -diff : diff;
            for (k = 0; k < run_len; k++) begin
               if (t == last_time) begin
                  interp = {{2{last_value[VW-1]}}, last_value};
               end else begin
                  // exact product, quotient truncated, sign applied afterwards
                  product = 96'(mag) * 96'(grid - {1'b0, last_time});
                  quotient = product / 96'(t - last_time);
                  interp = diff[VW] ?
                     {{2{last_value[VW-1]}}, last_value} - quotient[VW+1:0] :
                     {{2{last_value[VW-1]}}, last_value} + quotient[VW+1:0];
               end
               expect_sample(grid[TW-1:0], interp[VW-1:0], (k == run_len - 1),
                             lir_pkg::ST_OK);
               grid = grid + step_eff;
            end
            next_grid = grid;
            last_time = t;
            last_value = v;
         end
      end
   endtask

   // one point transfer, with optional idle cycles before it
   task automatic send_point(input logic start, input logic [TW-1:0] t,
                             input logic [VW-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid = 1'b1;
      req_series_start = start;
      req_point_time = t;
      req_point_value = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_point(start, t, v);
      @(negedge clock);
   endtask

   // waits until every expected sample is out and the block has settled
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_grid_step(input logic [SW-1:0] value);
      csr_valid = 1'b1;
      csr_grid_step = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      grid_step_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [VW-1:0] random_value();
      case ($urandom_range(7))
         0: return {1'b1, {(VW-1){1'b0}}};
         1: return {1'b0, {(VW-1){1'b1}}};
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // mostly ordered series with random content, some broken points
   task automatic random_point();
      longint unsigned stride;
      longint unsigned t_next;
      int              pick;
      stride = (grid_step_reg == '0) ? 1 : grid_step_reg;
      pick = $urandom_range(99);
      if (!gen_open || pick < 6) begin
         t_next = $urandom_range(1) ? longint'($urandom) : longint'($urandom_range(1000, 0));
         send_point(1'b1, TW'(t_next), random_value());
      end else if (pick < 10) begin
         // earlier than the open series
         t_next = (gen_time == 0) ? 0 : $urandom_range(32'(gen_time - 1), 0);
         send_point(1'b0, TW'(t_next), random_value());
         t_next = gen_time;
      end else begin
         if (pick < 13)
            t_next = gen_time + stride * (RUN_LIMIT + $urandom_range(8, 1));
         else if (pick < 17)
            t_next = gen_time;
         else
            t_next = gen_time + stride * $urandom_range(4, 0) +
                     $urandom_range(32'(stride - 1), 0);
         if (t_next > TIME_MAX) begin
            t_next = $urandom_range(1000, 0);
            send_point(1'b1, TW'(t_next), random_value());
         end else begin
            send_point(1'b0, TW'(t_next), random_value());
         end
      end
      gen_time = t_next;
      gen_open = 1'b1;
   endtask

   // corner cases at the default step and at extreme steps
   task automatic test_directed_cases();
      send_point(1'b0, 100, 32'h0001_0000);      // opens with no series open
      send_point(1'b0, 100, 32'h7FFF_0000);      // zero-length first segment
      send_point(1'b0, 50, 5);                   // out of order
      send_point(1'b0, 100, 7);                  // no grid time in segment
      send_point(1'b0, 110, 32'hFFFB_0000);      // ten samples, falling
      send_point(1'b0, 300, 3);                  // run overflow
      send_point(1'b0, 363, 32'h0001_2345);      // exactly the longest run
      send_point(1'b0, 428, 32'h0000_0042);      // one past the longest run
      send_point(1'b1, 0, 32'h8000_0000);        // series start while open
      send_point(1'b0, 40, 32'h7FFF_FFFF);       // widest rising difference
      send_point(1'b0, 41, 32'h8000_0000);       // widest falling difference
      send_point(1'b1, 32'hFFFF_FFC0, 0);
      send_point(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_point(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // grid beyond time range
      send_point(1'b0, 32'hFFFF_FFFE, 5);        // out of order at the top
      // quarter-range step gives near full width products
      wait_for_drain();
      write_grid_step(32'h4000_0000);
      send_point(1'b1, 0, 32'h7FFF_FFFF);
      send_point(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
      wait_for_drain();
      write_grid_step(32'hFFFF_FFFF);
      send_point(1'b1, 5, 1234);
      send_point(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFB3);
      send_point(1'b0, 32'hFFFF_FFFF, 9);
      wait_for_drain();
      write_grid_step(0);
      send_point(1'b1, 10, 0);
      send_point(1'b0, 13, 3000);
   endtask

   // random series under four idle patterns and grid steps
   task automatic test_random_phases();
      int phase;
      int k;
      for (phase = 0; phase < 4; phase++) begin
         wait_for_drain();
         gen_open = 1'b0;
         case (phase)
            0: begin
               write_grid_step(3);
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               write_grid_step($urandom_range(50, 2));
               send_idle_pct = 86;
               recv_stall_pct = 0;
            end
            2: begin
               write_grid_step($urandom_range(1 << 20, 1000));
               send_idle_pct = 0;
               recv_stall_pct = 86;
            end
            default: begin
               write_grid_step(1);
               send_idle_pct = 14;
               recv_stall_pct = 14;
            end
         endcase
         for (k = 0; k < 80; k++) random_point();
      end
   endtask

   // receiver holds off so the queue fills, then the sender waits for empty
   task automatic test_backpressure();
      int k;
      wait_for_drain();
      write_grid_step(1);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 700;
      send_point(1'b1, 1000, random_value());
      for (k = 1; k <= 20; k++) send_point(1'b0, 1000 + 4 * k, random_value());
      wait_for_drain();
      recv_stall_pct = 50;
      for (k = 21; k <= 26; k++) send_point(1'b0, 1000 + 4 * k, random_value());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_random_phases();
      test_backpressure();
      wait_for_drain();
      if (fail_count == 0) begin
         $display("linear_interp_resampler_top_test: PASS");
      end else begin
         $display("linear_interp_resampler_top_test: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/lir_pkg.sv
hdl/lir_queue.sv
hdl/lir_front.sv
hdl/lir_back.sv
hdl/linear_interp_resampler_top.sv
test/linear_interp_resampler_top_test.sv
